>>> design/jse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg: shared types and constants of the JSON string escaper
// Descriptor passed from the classifier to the output sequencer, byte codes
// of the escaped text and the hex digit lookup.
// ----------------------------------------------------------------------------
package jse_pkg;

	typedef enum logic [1:0] {
		KIND_END,
		KIND_PLAIN,
		KIND_SHORT,
		KIND_UNI
	} kind_t;

	typedef struct packed {
		logic       open;
		kind_t      kind;
		logic [7:0] val;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	localparam logic [7:0] CTRL_LIMIT = 8'd32;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'h0, nib};
		end else begin
			r = 8'h37 + {4'h0, nib};
		end
		return r;
	endfunction

endpackage

>>> design/jse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_front: input classifier
// Accepts string bytes, tracks the open-string flag and turns each byte into
// a descriptor for the output sequencer.
// ----------------------------------------------------------------------------
module jse_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	input  logic           q_full,
	output logic           push,
	output jse_pkg::desc_t desc
);
	import jse_pkg::*;

	logic in_string_q;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
		end else if (push) begin
			in_string_q <= (data_byte != CH_NUL);
		end
	end

	always_comb begin
		desc.open = !in_string_q;
		desc.val  = data_byte;
		priority if (data_byte == CH_NUL) begin
			desc.kind = KIND_END;
		end else if (data_byte == CH_QUOTE || data_byte == CH_BSL) begin
			desc.kind = KIND_SHORT;
		end else if (data_byte >= CTRL_LIMIT) begin
			desc.kind = KIND_PLAIN;
		end else begin
			desc.kind = KIND_UNI;
			unique case (data_byte)
				CH_BS:  begin desc.kind = KIND_SHORT; desc.val = CH_B; end
				CH_FF:  begin desc.kind = KIND_SHORT; desc.val = CH_F; end
				CH_LF:  begin desc.kind = KIND_SHORT; desc.val = CH_N; end
				CH_CR:  begin desc.kind = KIND_SHORT; desc.val = CH_R; end
				CH_TAB: begin desc.kind = KIND_SHORT; desc.val = CH_T; end
				default: begin end
			endcase
		end
	end

endmodule

>>> design/jse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_queue: descriptor queue
// Small first-in first-out buffer between classifier and sequencer; the head
// word is visible combinationally.
// ----------------------------------------------------------------------------
module jse_queue #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             nonempty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign rdata    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/jse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_back: output sequencer
// Walks the head descriptor one output byte per cycle, unless the output
// stalls, into the output register and pops it after its last byte.
// ----------------------------------------------------------------------------
module jse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nonempty,
	input  jse_pkg::desc_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           run_last,
	output logic           string_end
);
	import jse_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] base_n;
	logic [2:0] last_idx;
	logic [2:0] j;
	logic       is_last;
	logic       load;
	logic [7:0] nxt_byte;
	logic       nxt_end;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       string_end_q;

	always_comb begin
		unique case (head.kind)
			KIND_END:   base_n = 3'd1;
			KIND_PLAIN: base_n = 3'd1;
			KIND_SHORT: base_n = 3'd2;
			KIND_UNI:   base_n = 3'd6;
			default:    base_n = 3'd1;
		endcase
	end

	assign last_idx = base_n - 3'd1 + {2'b00, head.open};
	assign is_last  = (idx_q == last_idx);
	assign j        = idx_q - {2'b00, head.open};
	assign load     = q_nonempty && (!out_valid_q || !out_stall);
	assign pop      = load && is_last;

	always_comb begin
		nxt_byte = CH_QUOTE;
		nxt_end  = 1'b0;
		if (head.open && idx_q == 3'd0) begin
			nxt_byte = CH_QUOTE;
		end else begin
			unique case (head.kind)
				KIND_END: begin
					nxt_byte = CH_QUOTE;
					nxt_end  = 1'b1;
				end
				KIND_PLAIN: nxt_byte = head.val;
				KIND_SHORT: nxt_byte = (j == 3'd0) ? CH_BSL : head.val;
				KIND_UNI: begin
					unique case (j)
						3'd0:    nxt_byte = CH_BSL;
						3'd1:    nxt_byte = CH_U;
						3'd2:    nxt_byte = CH_ZERO;
						3'd3:    nxt_byte = CH_ZERO;
						3'd4:    nxt_byte = hex_char(head.val[7:4]);
						default: nxt_byte = hex_char(head.val[3:0]);
					endcase
				end
				default: nxt_byte = CH_QUOTE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= q_nonempty;
			end
			if (load) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= nxt_byte;
			run_last_q   <= is_last;
			string_end_q <= nxt_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

endmodule

>>> design/json_string_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper: streaming JSON string quoter and escaper
// Quotes and escapes a NUL-terminated byte string into JSON text.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+---------------------------------
//  in      | in_valid / in_stall   | data_byte
//  out     | out_valid / out_stall | out_byte, run_last, string_end
//
//  One input byte yields 1 to 7 output bytes, one output byte per cycle
//  unless out_stall holds. Plain bytes inside a string flow at one byte
//  per cycle; escapes take 2 or 6 bytes at the output sequencer, plus
//  one for an opening quote. An accepted byte passes the descriptor
//  queue and the output register first. in_stall rises only when the
//  queue is full. Reset clears the open-string flag, queue and out_valid.
// ----------------------------------------------------------------------------
module json_string_escaper #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_end
);
	import jse_pkg::*;

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_nonempty;
	desc_t desc;
	desc_t head;
	logic [DESC_W-1:0] head_bits;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.desc      (desc)
	);

	jse_queue #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (desc),
		.pop      (pop),
		.rdata    (head_bits),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	assign head = desc_t'(head_bits);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

>>> design/jse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_checker: port-level checks of the JSON string escaper
// Watches the output channel for escaper-specific ordering and hold rules.
// ----------------------------------------------------------------------------
module jse_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	input  logic       string_end
);
	import jse_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(run_last) && $stable(string_end))
		else $error("stalled output word changed");

	a_end_quote: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> out_byte == CH_QUOTE && run_last)
		else $error("string end without closing quote as last byte");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("gap inside the output burst of one input byte");

	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_byte   (out_byte),
	.run_last   (run_last),
	.string_end (string_end)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the JSON string escaper
// Feeds directed and random, mostly NUL-terminated strings at random idle
// and stall, predicts the quoted, escaped output word by word and compares
// each accepted output word with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
	import jse_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 80;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [7:0] text;
		logic       run_end;
		logic       str_end;
	} esc_word_t;

	class escape_scoreboard;
		esc_word_t expected[$];
		bit        open_str;
		int        errors;

		function new();
			open_str = 0;
			errors   = 0;
		endfunction

		function logic [7:0] hex_ascii(input logic [3:0] nib);
			if (nib < 4'd10) begin
				return CH_ZERO + {4'h0, nib};
			end
			return 8'h41 + {4'h0, nib} - 8'd10;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void note_word(input logic [7:0] b);
			logic [7:0] seq[$];
			esc_word_t  w;
			if (!open_str) begin
				seq.push_back(CH_QUOTE);
				open_str = 1;
			end
			if (b == CH_NUL) begin
				seq.push_back(CH_QUOTE);
				open_str = 0;
			end else if (b >= CTRL_LIMIT && b != CH_QUOTE && b != CH_BSL) begin
				seq.push_back(b);
			end else begin
				seq.push_back(CH_BSL);
				case (b)
					CH_QUOTE, CH_BSL: seq.push_back(b);
					CH_BS: seq.push_back(CH_B);
					CH_FF: seq.push_back(CH_F);
					CH_LF: seq.push_back(CH_N);
					CH_CR: seq.push_back(CH_R);
					CH_TAB: seq.push_back(CH_T);
					default: begin
						seq.push_back(CH_U);
						seq.push_back(CH_ZERO);
						seq.push_back(CH_ZERO);
						seq.push_back(hex_ascii(b[7:4]));
						seq.push_back(hex_ascii(b[3:0]));
					end
				endcase
			end
			foreach (seq[i]) begin
				w.text    = seq[i];
				w.run_end = (i == seq.size() - 1);
				w.str_end = (b == CH_NUL) && (i == seq.size() - 1);
				expected.push_back(w);
			end
		endfunction

		function void check_word(input logic [7:0] ob, input logic rl, input logic se);
			esc_word_t w;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected word: byte %h run_last %b string_end %b", ob, rl, se);
				end
				return;
			end
			w = expected.pop_front();
			if (w.text !== ob || w.run_end !== rl || w.str_end !== se) begin
				errors++;
				if (errors <= 10) begin
					$display("word mismatch: expected %h/%b/%b, got %h/%b/%b",
						w.text, w.run_end, w.str_end, ob, rl, se);
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	escape_scoreboard sb;
	bit               calm;
	int               cycles;
	int               sent;

	json_string_escaper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.string_end(string_end)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("json_string_escaper: mismatch");
			$finish;
		end
	end

	// check accepted output words, then pick the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_word(out_byte, run_last, string_end);
			end
			out_stall <= !calm && ($urandom_range(99) < 13);
		end
	end

	task automatic send_word(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_word(b);
		sent++;
	endtask

	task automatic drain_output();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_text_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			return 8'($urandom_range(8'h7E, 8'h20));
		end else if (pick < 70) begin
			return 8'($urandom_range(31, 1));
		end else if (pick < 82) begin
			return 8'($urandom_range(255, 128));
		end else if (pick < 91) begin
			return CH_QUOTE;
		end
		return CH_BSL;
	endfunction

	task automatic send_string(input int len, input bit terminate);
		for (int i = 0; i < len; i++) begin
			send_word(random_text_byte());
		end
		if (terminate) begin
			send_word(CH_NUL);
		end
	endtask

	initial begin
		logic [7:0] directed[$];
		int         strings;
		int         target;
		sb        = new();
		calm      = 0;
		cycles    = 0;
		sent      = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		out_stall = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{CH_NUL, 8'h41, CH_QUOTE, CH_BSL, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB,
			8'h01, 8'h1F, 8'h2F, 8'h20, 8'h7F, 8'h80, 8'hFF, CH_NUL,
			8'h1A, CH_NUL, CH_NUL, 8'h55, 8'hAA, CH_NUL};
		foreach (directed[i]) begin
			send_word(directed[i]);
		end

		// hold the sender until every expected word is out
		drain_output();

		strings = 0;
		target  = sent + RANDOM_ITEMS;
		while (sent < target) begin
			calm = (strings >= 4 && strings < 8);
			send_string($urandom_range(8), $urandom_range(9) != 0);
			strings++;
		end
		calm = 0;

		drain_output();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("json_string_escaper: match");
		end else begin
			$display("json_string_escaper: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
design/jse_pkg.sv
design/jse_front.sv
design/jse_queue.sv
design/jse_back.sv
design/json_string_escaper.sv
design/jse_checker.sv
test/tb.sv
